// ----- rtl/lcsl_pkg.sv -----
`timescale 1ns / 1ps

package lcsl_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_ITEMS_DEF = 64;
  localparam int KEY_BITS_DEF  = 16;

  // Fixed field widths on the ports
  localparam int FIELD_W = 16;
  localparam int COUNT_W = 7;

  // Input kind carried on tuser
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RK_RI,   // read item i for ranking
    ST_RK_LI,   // latch item i
    ST_RK_RJ,   // read item j
    ST_RK_CJ,   // compare item j against item i
    ST_RK_WR,   // write item i at its sorted place
    ST_LI_RD,   // read sorted key i and current last tail
    ST_LI_CMP,  // append or start binary search
    ST_BS_RD,   // read tail at midpoint
    ST_BS_CMP,  // narrow search window
    ST_FIN_RD,  // read tail at final place
    ST_FIN_CMP, // replace tail if key is larger
    ST_PRE_RD,  // read tail below the replaced one
    ST_PRE_WR,  // write predecessor link
    ST_RB_RT,   // read last tail to start rebuild
    ST_RB_LT,   // latch start of rebuild
    ST_RB_WR,   // store chain member, read its link
    ST_RB_PR,   // follow link
    ST_OUT_RT,  // read chain member position
    ST_OUT_RS,  // read arrival index of that position
    ST_OUT_SEND // hand result to output register
  } lcsl_state_e;

endpackage

// ----- rtl/longest_chain_sort_lis_unit.sv -----
`timescale 1ns / 1ps

// Longest chain unit: collects up to MAX_ITEMS (weight, key) items, then on
// finish orders them by weight, key and arrival, and reports the longest chain
// with strictly increasing weight and strictly decreasing key.
// Input stream: tuser = command (0 load, 1 finish); tdata = weight, key_value.
// Output stream: one transfer per chain member, in chain order; tdata carries
// chain_length, item_number (arrival number from 1) and dropped; tlast marks
// the final member. An empty set gives one transfer with length 0.
// Loads past capacity are dropped and flagged.
// Finish with n items: ranking compares each item with every item through one
// shared comparator against one item RAM read port; then come the chain search,
// the rebuild and the output.
// tready is low for the whole finish. A stall on the output holds the current
// result in the output register and holds the sequencer in its send state.
// Reset empties the set and the overflow flag; RAM contents are not cleared
// and are only used where written. After finish the set is empty again.
module longest_chain_sort_lis_unit #(
  parameter int MAX_ITEMS = lcsl_pkg::MAX_ITEMS_DEF,
  parameter int KEY_BITS  = lcsl_pkg::KEY_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] weight, [31:16] key_value
  input  logic        s_axis_tuser_i,   // [0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [6:0] chain_length, [13:7] item_number,
                                        // [14] dropped, [15] zero
  output logic        m_axis_tlast_o
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int KB = KEY_BITS;
  localparam int FW = lcsl_pkg::FIELD_W;
  localparam int NW = lcsl_pkg::COUNT_W;

  lcsl_pkg::lcsl_state_e state_q, state_d;

  logic [CW-1:0] cnt_q, i_q, j_q, rank_q, len_q, u_q, v_q, k_q;
  logic          ovf_q;
  logic [KB-1:0] wi_q, ki_q;
  logic [AW-1:0] rb_pos_q;

  logic          mv_q, mlast_q, mdrop_q;
  logic [NW-1:0] mlen_q, mnum_q;

  // RAM ports
  logic          it_we, so_we, tl_we, pr_we;
  logic [AW-1:0] it_wa, it_ra, so_wa, so_ra, tl_wa, tl_ra, pr_wa, pr_ra;
  logic [2*KB-1:0] it_wd, it_rd;
  logic [KB+AW-1:0] so_wd, so_rd, tl_wd, tl_rd;
  logic [AW-1:0] pr_wd, pr_rd;

  // Field views
  logic [31:0]   w_ext, k_ext;
  logic [KB-1:0] in_w, in_k, it_w, it_k, so_k, tl_k;
  logic [AW-1:0] so_idx, tl_pos;
  logic          s_acc, out_free, j_before, res_load;
  logic [CW:0]   uv_sum;
  logic [CW-1:0] mid, len_m1, n_m1;

  assign w_ext  = 32'(s_axis_tdata_i[FW-1:0]);
  assign k_ext  = 32'(s_axis_tdata_i[2*FW-1:FW]);
  assign in_w   = w_ext[KB-1:0];
  assign in_k   = k_ext[KB-1:0];
  assign it_w   = it_rd[KB-1:0];
  assign it_k   = it_rd[2*KB-1:KB];
  assign so_idx = so_rd[AW-1:0];
  assign so_k   = so_rd[KB+AW-1:AW];
  assign tl_pos = tl_rd[AW-1:0];
  assign tl_k   = tl_rd[KB+AW-1:AW];

  assign uv_sum = {1'b0, u_q} + {1'b0, v_q};
  assign mid    = uv_sum[CW:1];
  assign len_m1 = len_q - CW'(1);
  assign n_m1   = cnt_q - CW'(1);

  assign out_free = !mv_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == lcsl_pkg::ST_IDLE) && out_free;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // A new result enters the output register
  assign res_load = ((state_q == lcsl_pkg::ST_IDLE) && s_acc &&
                     (s_axis_tuser_i == lcsl_pkg::CMD_FINISH) && (cnt_q == '0)) ||
                    ((state_q == lcsl_pkg::ST_OUT_SEND) && out_free);

  // Item j sorts before held item i (ties by arrival)
  assign j_before = (it_w < wi_q) ||
                    ((it_w == wi_q) && (it_k < ki_q)) ||
                    ((it_w == wi_q) && (it_k == ki_q) && (j_q < i_q));

  lcsl_ram #(.W(2*KB), .DEPTH(MAX_ITEMS), .AW(AW)) u_items (
    .clk_i, .we_i(it_we), .waddr_i(it_wa), .wdata_i(it_wd), .raddr_i(it_ra),
    .rdata_o(it_rd)
  );
  lcsl_ram #(.W(KB+AW), .DEPTH(MAX_ITEMS), .AW(AW)) u_sorted (
    .clk_i, .we_i(so_we), .waddr_i(so_wa), .wdata_i(so_wd), .raddr_i(so_ra),
    .rdata_o(so_rd)
  );
  lcsl_ram #(.W(KB+AW), .DEPTH(MAX_ITEMS), .AW(AW)) u_tails (
    .clk_i, .we_i(tl_we), .waddr_i(tl_wa), .wdata_i(tl_wd), .raddr_i(tl_ra),
    .rdata_o(tl_rd)
  );
  lcsl_ram #(.W(AW), .DEPTH(MAX_ITEMS), .AW(AW)) u_links (
    .clk_i, .we_i(pr_we), .waddr_i(pr_wa), .wdata_i(pr_wd), .raddr_i(pr_ra),
    .rdata_o(pr_rd)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lcsl_pkg::ST_IDLE: begin
        if (s_acc && (s_axis_tuser_i == lcsl_pkg::CMD_FINISH) && (cnt_q != '0)) begin
          state_d = lcsl_pkg::ST_RK_RI;
        end
      end
      lcsl_pkg::ST_RK_RI: state_d = lcsl_pkg::ST_RK_LI;
      lcsl_pkg::ST_RK_LI: state_d = lcsl_pkg::ST_RK_RJ;
      lcsl_pkg::ST_RK_RJ: state_d = lcsl_pkg::ST_RK_CJ;
      lcsl_pkg::ST_RK_CJ: begin
        state_d = (j_q == n_m1) ? lcsl_pkg::ST_RK_WR : lcsl_pkg::ST_RK_RJ;
      end
      lcsl_pkg::ST_RK_WR: begin
        state_d = (i_q == n_m1) ? lcsl_pkg::ST_LI_RD : lcsl_pkg::ST_RK_RI;
      end
      lcsl_pkg::ST_LI_RD: state_d = lcsl_pkg::ST_LI_CMP;
      lcsl_pkg::ST_LI_CMP: begin
        if ((len_q == '0) || (tl_k > so_k)) begin
          state_d = (i_q == n_m1) ? lcsl_pkg::ST_RB_RT : lcsl_pkg::ST_LI_RD;
        end else if (len_m1 != '0) begin
          state_d = lcsl_pkg::ST_BS_RD;
        end else begin
          state_d = lcsl_pkg::ST_FIN_RD;
        end
      end
      lcsl_pkg::ST_BS_RD: state_d = lcsl_pkg::ST_BS_CMP;
      lcsl_pkg::ST_BS_CMP: begin
        if (tl_k > ki_q) begin
          state_d = ((mid + CW'(1)) < v_q) ? lcsl_pkg::ST_BS_RD : lcsl_pkg::ST_FIN_RD;
        end else begin
          state_d = (u_q < mid) ? lcsl_pkg::ST_BS_RD : lcsl_pkg::ST_FIN_RD;
        end
      end
      lcsl_pkg::ST_FIN_RD: state_d = lcsl_pkg::ST_FIN_CMP;
      lcsl_pkg::ST_FIN_CMP: begin
        if ((ki_q > tl_k) && (u_q != '0)) begin
          state_d = lcsl_pkg::ST_PRE_RD;
        end else begin
          state_d = (i_q == n_m1) ? lcsl_pkg::ST_RB_RT : lcsl_pkg::ST_LI_RD;
        end
      end
      lcsl_pkg::ST_PRE_RD: state_d = lcsl_pkg::ST_PRE_WR;
      lcsl_pkg::ST_PRE_WR: begin
        state_d = (i_q == n_m1) ? lcsl_pkg::ST_RB_RT : lcsl_pkg::ST_LI_RD;
      end
      lcsl_pkg::ST_RB_RT: state_d = lcsl_pkg::ST_RB_LT;
      lcsl_pkg::ST_RB_LT: state_d = lcsl_pkg::ST_RB_WR;
      lcsl_pkg::ST_RB_WR: state_d = lcsl_pkg::ST_RB_PR;
      lcsl_pkg::ST_RB_PR: begin
        state_d = (k_q == '0) ? lcsl_pkg::ST_OUT_RT : lcsl_pkg::ST_RB_WR;
      end
      lcsl_pkg::ST_OUT_RT: state_d = lcsl_pkg::ST_OUT_RS;
      lcsl_pkg::ST_OUT_RS: state_d = lcsl_pkg::ST_OUT_SEND;
      lcsl_pkg::ST_OUT_SEND: begin
        if (out_free) begin
          state_d = (k_q == len_m1) ? lcsl_pkg::ST_IDLE : lcsl_pkg::ST_OUT_RT;
        end
      end
      default: state_d = lcsl_pkg::ST_IDLE;
    endcase
  end

  // RAM control per state
  always_comb begin
    it_we = 1'b0;
    it_wa = cnt_q[AW-1:0];
    it_wd = {in_k, in_w};
    it_ra = j_q[AW-1:0];
    so_we = 1'b0;
    so_wa = rank_q[AW-1:0];
    so_wd = {ki_q, i_q[AW-1:0]};
    so_ra = i_q[AW-1:0];
    tl_we = 1'b0;
    tl_wa = u_q[AW-1:0];
    tl_wd = {ki_q, i_q[AW-1:0]};
    tl_ra = len_m1[AW-1:0];
    pr_we = 1'b0;
    pr_wa = i_q[AW-1:0];
    pr_wd = tl_pos;
    pr_ra = rb_pos_q;
    case (state_q)
      lcsl_pkg::ST_IDLE: begin
        it_we = s_acc && (s_axis_tuser_i == lcsl_pkg::CMD_LOAD) &&
                (cnt_q < CW'(MAX_ITEMS));
      end
      lcsl_pkg::ST_RK_RI: it_ra = i_q[AW-1:0];
      lcsl_pkg::ST_RK_WR: so_we = 1'b1;
      lcsl_pkg::ST_LI_CMP: begin
        if ((len_q == '0) || (tl_k > so_k)) begin
          pr_we = 1'b1;
          tl_we = 1'b1;
          tl_wa = len_q[AW-1:0];
          tl_wd = {so_k, i_q[AW-1:0]};
        end
      end
      lcsl_pkg::ST_BS_RD:   tl_ra = mid[AW-1:0];
      lcsl_pkg::ST_FIN_RD:  tl_ra = u_q[AW-1:0];
      lcsl_pkg::ST_FIN_CMP: tl_we = (ki_q > tl_k);
      lcsl_pkg::ST_PRE_RD:  tl_ra = u_q[AW-1:0] - AW'(1);
      lcsl_pkg::ST_PRE_WR:  pr_we = 1'b1;
      lcsl_pkg::ST_RB_WR: begin
        tl_we = 1'b1;
        tl_wa = k_q[AW-1:0];
        tl_wd = {ki_q, rb_pos_q};
      end
      lcsl_pkg::ST_OUT_RT, lcsl_pkg::ST_OUT_RS, lcsl_pkg::ST_OUT_SEND: begin
        tl_ra = k_q[AW-1:0];
        so_ra = tl_pos;
      end
      default: ;
    endcase
  end

  // Sequencer datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lcsl_pkg::ST_IDLE;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      rank_q   <= '0;
      len_q    <= '0;
      u_q      <= '0;
      v_q      <= '0;
      k_q      <= '0;
      wi_q     <= '0;
      ki_q     <= '0;
      rb_pos_q <= '0;
      mv_q     <= 1'b0;
      mlast_q  <= 1'b0;
      mdrop_q  <= 1'b0;
      mlen_q   <= '0;
      mnum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        mv_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        mv_q <= 1'b0;
      end
      case (state_q)
        lcsl_pkg::ST_IDLE: begin
          i_q   <= '0;
          len_q <= '0;
          if (s_acc && (s_axis_tuser_i == lcsl_pkg::CMD_LOAD)) begin
            if (cnt_q < CW'(MAX_ITEMS)) begin
              cnt_q <= cnt_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end else if (s_acc && (cnt_q == '0)) begin
            // empty set: single result of length zero
            mlen_q  <= '0;
            mnum_q  <= '0;
            mdrop_q <= ovf_q;
            mlast_q <= 1'b1;
            ovf_q   <= 1'b0;
          end
        end
        lcsl_pkg::ST_RK_LI: begin
          wi_q   <= it_w;
          ki_q   <= it_k;
          j_q    <= '0;
          rank_q <= '0;
        end
        lcsl_pkg::ST_RK_CJ: begin
          rank_q <= rank_q + CW'(j_before);
          j_q    <= j_q + CW'(1);
        end
        lcsl_pkg::ST_RK_WR: begin
          if (i_q == n_m1) begin
            i_q   <= '0;
            len_q <= '0;
          end else begin
            i_q <= i_q + CW'(1);
          end
        end
        lcsl_pkg::ST_LI_CMP: begin
          ki_q <= so_k;
          u_q  <= '0;
          v_q  <= len_m1;
          if ((len_q == '0) || (tl_k > so_k)) begin
            len_q <= len_q + CW'(1);
            i_q   <= i_q + CW'(1);
          end
        end
        lcsl_pkg::ST_BS_CMP: begin
          if (tl_k > ki_q) begin
            u_q <= mid + CW'(1);
          end else begin
            v_q <= mid;
          end
        end
        lcsl_pkg::ST_FIN_CMP: begin
          if (!((ki_q > tl_k) && (u_q != '0))) begin
            i_q <= i_q + CW'(1);
          end
        end
        lcsl_pkg::ST_PRE_WR: i_q <= i_q + CW'(1);
        lcsl_pkg::ST_RB_LT: begin
          rb_pos_q <= tl_pos;
          k_q      <= len_m1;
        end
        lcsl_pkg::ST_RB_PR: begin
          rb_pos_q <= pr_rd;
          if (k_q != '0) begin
            k_q <= k_q - CW'(1);
          end
        end
        lcsl_pkg::ST_OUT_SEND: begin
          if (out_free) begin
            mlen_q  <= NW'(len_q);
            mnum_q  <= NW'(so_idx) + NW'(1);
            mdrop_q <= ovf_q;
            mlast_q <= (k_q == len_m1);
            if (k_q == len_m1) begin
              cnt_q <= '0;
              ovf_q <= 1'b0;
            end else begin
              k_q <= k_q + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tlast_o  = mlast_q;
  assign m_axis_tdata_o  = {1'b0, mdrop_q, mnum_q, mlen_q};

  // Chain never grows past the number of stored items
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lcsl_pkg::ST_IDLE) |-> (len_q <= cnt_q))
    else $error("chain length exceeds item count");

  // Binary search window is never empty while searching
  a_bs_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcsl_pkg::ST_BS_CMP) |-> (u_q < v_q))
    else $error("empty search window");

  // A zero-length result is always the only and final one
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (mlen_q == '0)) |-> (m_axis_tlast_o && (mnum_q == '0)))
    else $error("empty result not marked last");

  // Store is empty after the final result is loaded
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lcsl_pkg::ST_OUT_SEND) && out_free && (k_q == len_m1))
      |=> ((cnt_q == '0) && !ovf_q))
    else $error("store not cleared after finish");

endmodule

// ----- rtl/lcsl_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data
module lcsl_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- verif/longest_chain_sort_lis_unit_tb.sv -----
`timescale 1ns / 1ps

module longest_chain_sort_lis_unit_tb;

  localparam int CAP = lcsl_pkg::MAX_ITEMS_DEF;

  typedef struct packed {
    logic        cmd;
    logic [15:0] weight;
    logic [15:0] key_value;
  } load_item_t;

  typedef struct packed {
    logic [6:0] chain_length;
    logic [6:0] item_number;
    logic       dropped;
    logic       last;
  } chain_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // [15:0] weight, [31:16] key_value
  logic        s_axis_tuser_i;   // [0] command
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;   // [6:0] chain_length, [13:7] item_number, [14] dropped
  logic        m_axis_tlast_o;

  longest_chain_sort_lis_unit dut (.*);

  load_item_t pending_q[$];
  chain_res_t chain_exp_q[$];

  // DUT outputs captured at the falling edge
  logic        s_rdy_s;
  logic        m_vld_s;
  logic [15:0] m_data_s;
  logic        m_last_s;

  // predictor state
  logic [15:0] set_w[CAP];
  logic [15:0] set_k[CAP];
  int          set_n;
  logic        set_ovf;

  int  mismatches;
  int  results_seen;
  int  finishes;
  bit  no_idle;
  bit  stim_done;

  function automatic void add_item(load_item_t it);
    pending_q.insert(pending_q.size(), it);
  endfunction

  function automatic void add_expect(chain_res_t r);
    chain_exp_q.insert(chain_exp_q.size(), r);
  endfunction

  // Predict the longest chain for the current set and clear the set.
  task automatic predict_finish();
    int ord[CAP];
    int tails[CAP];
    int links[CAP];
    int chain[CAP];
    int len, j, u, v, c, p;
    chain_res_t r;
    if (set_n == 0) begin
      r = '{7'd0, 7'd0, set_ovf, 1'b1};
      add_expect(r);
    end else begin
      // stable insertion sort by weight then key
      for (int i = 0; i < set_n; i++) begin
        j = i;
        while (j > 0 && (set_w[i] < set_w[ord[j-1]] ||
               (set_w[i] == set_w[ord[j-1]] && set_k[i] < set_k[ord[j-1]]))) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = i;
      end
      for (int i = 0; i < CAP; i++) links[i] = 0;
      tails[0] = 0;
      len = 1;
      for (int i = 1; i < set_n; i++) begin
        if (set_k[ord[tails[len-1]]] > set_k[ord[i]]) begin
          links[i] = tails[len-1];
          tails[len] = i;
          len++;
        end else begin
          u = 0;
          v = len - 1;
          while (u < v) begin
            c = (u + v) / 2;
            if (set_k[ord[tails[c]]] > set_k[ord[i]]) u = c + 1;
            else v = c;
          end
          if (set_k[ord[i]] > set_k[ord[tails[u]]]) begin
            if (u > 0) links[i] = tails[u-1];
            tails[u] = i;
          end
        end
      end
      p = tails[len-1];
      for (int k = len - 1; k >= 0; k--) begin
        chain[k] = p;
        p = links[p];
      end
      for (int k = 0; k < len; k++) begin
        r.chain_length = 7'(len);
        r.item_number  = 7'(ord[chain[k]] + 1);
        r.dropped      = set_ovf;
        r.last         = (k == len - 1);
        add_expect(r);
      end
    end
    set_n = 0;
    set_ovf = 1'b0;
    finishes++;
  endtask

  function automatic load_item_t mk(logic cmd, int w, int k);
    mk = '{cmd, 16'(w), 16'(k)};
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // capture DUT outputs while they are settled
  always @(negedge clk_i) begin
    s_rdy_s  = s_axis_tready_o;
    m_vld_s  = m_axis_tvalid_o;
    m_data_s = m_axis_tdata_o;
    m_last_s = m_axis_tlast_o;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_rdy_s) begin
        // transfer accepted: update prediction
        if (s_axis_tuser_i == lcsl_pkg::CMD_FINISH) predict_finish();
        else if (set_n < CAP) begin
          set_w[set_n] = s_axis_tdata_i[15:0];
          set_k[set_n] = s_axis_tdata_i[31:16];
          set_n++;
        end else set_ovf = 1'b1;
        void'(pending_q.pop_front());
      end
      if (pending_q.size() > 0 && (!s_axis_tvalid_i || s_rdy_s) &&
          (no_idle || $urandom_range(99) >= 14)) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i  <= pending_q[0].cmd;
        s_axis_tdata_i  <= {pending_q[0].key_value, pending_q[0].weight};
      end else if (!s_axis_tvalid_i || s_rdy_s) begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin
    chain_res_t act, exp_r;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_vld_s && m_axis_tready_i) begin
        act = '{m_data_s[6:0], m_data_s[13:7], m_data_s[14], m_last_s};
        results_seen++;
        if (chain_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", act);
        end else begin
          exp_r = chain_exp_q.pop_front();
          if (act !== exp_r || m_data_s[15] !== 1'b0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p (bit15=%b)", exp_r, act,
                       m_data_s[15]);
          end
        end
      end
      m_axis_tready_i <= no_idle || ($urandom_range(99) >= 14);
    end
  end

  // stimulus
  initial begin
    int n_sets, sz, wr, kr;
    rst_ni = 1'b0;
    set_n = 0;
    set_ovf = 1'b0;
    mismatches = 0;
    results_seen = 0;
    finishes = 0;
    no_idle = 1'b0;
    stim_done = 1'b0;
    // directed: empty finish, extremes, equal keys, equal weights
    add_item(mk(lcsl_pkg::CMD_FINISH, 0, 0));
    add_item(mk(lcsl_pkg::CMD_LOAD, 0, 65535));
    add_item(mk(lcsl_pkg::CMD_LOAD, 65535, 0));
    add_item(mk(lcsl_pkg::CMD_LOAD, 65535, 0));
    add_item(mk(lcsl_pkg::CMD_LOAD, 0, 65535));
    add_item(mk(lcsl_pkg::CMD_LOAD, 100, 5));
    add_item(mk(lcsl_pkg::CMD_LOAD, 100, 9));
    add_item(mk(lcsl_pkg::CMD_LOAD, 50, 5));
    add_item(mk(lcsl_pkg::CMD_FINISH, 65535, 65535));
    add_item(mk(lcsl_pkg::CMD_LOAD, 7, 7));
    add_item(mk(lcsl_pkg::CMD_FINISH, 0, 0));
    // overflow: full store plus extra loads, then an empty set after clear
    for (int i = 0; i < CAP + 3; i++)
      add_item(mk(lcsl_pkg::CMD_LOAD, 1000 - i * 7 + (i % 3), 2000 + i * 11));
    add_item(mk(lcsl_pkg::CMD_FINISH, 0, 0));
    add_item(mk(lcsl_pkg::CMD_FINISH, 0, 0));
    // random sets, mostly small, often with narrow ranges to force ties
    n_sets = 0;
    while (n_sets < 6) begin
      sz = ($urandom_range(9) == 0) ? $urandom_range(CAP + 2) : $urandom_range(10);
      wr = ($urandom_range(1) == 0) ? 15 : 65535;
      kr = ($urandom_range(1) == 0) ? 15 : 65535;
      for (int i = 0; i < sz; i++)
        add_item(mk(lcsl_pkg::CMD_LOAD, $urandom_range(wr), $urandom_range(kr)));
      add_item(mk(lcsl_pkg::CMD_FINISH, $urandom, $urandom));
      n_sets++;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0);
    // steady stretch without idling
    no_idle = 1'b1;
    for (int i = 0; i < 15; i++)
      add_item(mk(lcsl_pkg::CMD_LOAD, $urandom, $urandom));
    add_item(mk(lcsl_pkg::CMD_FINISH, 0, 0));
    wait (pending_q.size() == 0);
    no_idle = 1'b0;
    wait (chain_exp_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d finishes and %0d chain results, incl. overflow and empty sets",
             finishes, results_seen);
    if (mismatches == 0 && chain_exp_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

  // timeout
  initial begin
    #20ms;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

endmodule
